>>> hdl/tspp_pkg.sv
// Shared types, constants and lookup functions for the proof header parser.
package tspp_pkg;

    localparam int MAGIC_LEN        = 31;
    localparam int MAX_DIGEST_BYTES = 32;
    localparam int POS_W            = 6;
    localparam int MAGIC_IDX_W      = 5;

    localparam logic [7:0] VERSION_RESET = 8'h01;

    localparam logic [7:0] ALG_SHA1      = 8'h02;
    localparam logic [7:0] ALG_RIPEMD160 = 8'h03;
    localparam logic [7:0] ALG_SHA256    = 8'h08;
    localparam logic [7:0] ALG_KECCAK256 = 8'h67;

    localparam logic [POS_W-1:0] LEN_SHORT = POS_W'(20);
    localparam logic [POS_W-1:0] LEN_LONG  = POS_W'(32);

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_VERSION = 3'd1,
        PH_ALGO    = 3'd2,
        PH_DIGEST  = 3'd3,
        PH_TAIL    = 3'd4,
        PH_ERROR   = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_MAGIC   = 3'd1,
        ST_OVERFLOW    = 3'd2,
        ST_CORRUPT     = 3'd3,
        ST_BAD_VERSION = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        TK_NONE    = 2'd0,
        TK_VERSION = 2'd1,
        TK_DIGEST  = 2'd2
    } t_token_kind;

    typedef struct packed {
        t_token_kind token_kind;
        logic [7:0]  hash_code;
        logic [7:0]  data_byte;
        logic        digest_end;
        logic        done_res;
        t_status     status;
    } t_result;

    // Expected byte of the fixed file header at a given position.
    function automatic logic [7:0] magic_byte(input logic [MAGIC_IDX_W-1:0] idx);
        logic [7:0] b;
        begin
            case (idx)
                5'd0:  b = 8'h00;
                5'd1:  b = 8'h4f;
                5'd2:  b = 8'h70;
                5'd3:  b = 8'h65;
                5'd4:  b = 8'h6e;
                5'd5:  b = 8'h54;
                5'd6:  b = 8'h69;
                5'd7:  b = 8'h6d;
                5'd8:  b = 8'h65;
                5'd9:  b = 8'h73;
                5'd10: b = 8'h74;
                5'd11: b = 8'h61;
                5'd12: b = 8'h6d;
                5'd13: b = 8'h70;
                5'd14: b = 8'h73;
                5'd15: b = 8'h00;
                5'd16: b = 8'h00;
                5'd17: b = 8'h50;
                5'd18: b = 8'h72;
                5'd19: b = 8'h6f;
                5'd20: b = 8'h6f;
                5'd21: b = 8'h66;
                5'd22: b = 8'h00;
                5'd23: b = 8'hbf;
                5'd24: b = 8'h89;
                5'd25: b = 8'he2;
                5'd26: b = 8'he8;
                5'd27: b = 8'h84;
                5'd28: b = 8'he8;
                5'd29: b = 8'h92;
                5'd30: b = 8'h94;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

    // Digest length for an algorithm code; zero means unknown or too long.
    function automatic logic [POS_W-1:0] code_digest_len(input logic [7:0] code);
        logic [POS_W-1:0] n;
        begin
            unique case (code) inside
                ALG_SHA1, ALG_RIPEMD160:   n = LEN_SHORT;
                ALG_SHA256, ALG_KECCAK256: n = LEN_LONG;
                default:                   n = '0;
            endcase
            if (int'(n) > MAX_DIGEST_BYTES) begin
                n = '0;
            end
            return n;
        end
    endfunction

endpackage

>>> hdl/tspp_core.sv
// Parse state machine: one byte per cycle while i_advance is high, result computed in the same cycle.
module tspp_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_data,
    output logic                  o_emit,
    output tspp_pkg::t_result     o_result
);

    tspp_pkg::t_phase                 r_phase, n_phase;
    logic [tspp_pkg::POS_W-1:0]       r_pos, n_pos;
    logic [tspp_pkg::POS_W-1:0]       r_dlen, n_dlen;
    logic [7:0]                       r_alg, n_alg;
    logic                             r_mismatch, n_mismatch;
    tspp_pkg::t_status                r_err, n_err;
    logic [7:0]                       r_version;

    logic [tspp_pkg::POS_W-1:0]       pos_inc;
    logic [tspp_pkg::POS_W-1:0]       code_len;
    logic                             emit_tok;
    tspp_pkg::t_result                res;

    assign pos_inc  = r_pos + tspp_pkg::POS_W'(1);
    assign code_len = tspp_pkg::code_digest_len(i_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= tspp_pkg::PH_MAGIC;
            r_pos      <= '0;
            r_dlen     <= '0;
            r_alg      <= '0;
            r_mismatch <= 1'b0;
            r_err      <= tspp_pkg::ST_OK;
            r_version  <= tspp_pkg::VERSION_RESET;
        end else begin
            if (i_advance) begin
                r_phase    <= n_phase;
                r_pos      <= n_pos;
                r_dlen     <= n_dlen;
                r_alg      <= n_alg;
                r_mismatch <= n_mismatch;
                r_err      <= n_err;
            end
            if (i_cfg_we) begin
                r_version <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_dlen     = r_dlen;
        n_alg      = r_alg;
        n_mismatch = r_mismatch;
        n_err      = r_err;
        emit_tok   = 1'b0;
        res        = '0;

        unique case (r_phase)
            tspp_pkg::PH_MAGIC: begin
                if (tspp_pkg::magic_byte(r_pos[tspp_pkg::MAGIC_IDX_W-1:0]) != i_byte) begin
                    n_mismatch = 1'b1;
                end
                n_pos = pos_inc;
                if (int'(pos_inc) >= tspp_pkg::MAGIC_LEN) begin
                    n_pos = '0;
                    if (n_mismatch) begin
                        n_phase = tspp_pkg::PH_ERROR;
                        n_err   = tspp_pkg::ST_BAD_MAGIC;
                    end else begin
                        n_phase = tspp_pkg::PH_VERSION;
                    end
                end
            end
            tspp_pkg::PH_VERSION: begin
                if (i_byte == r_version) begin
                    emit_tok       = 1'b1;
                    res.token_kind = tspp_pkg::TK_VERSION;
                    res.data_byte  = i_byte;
                    n_phase        = tspp_pkg::PH_ALGO;
                end else begin
                    n_phase = tspp_pkg::PH_ERROR;
                    n_err   = tspp_pkg::ST_BAD_VERSION;
                end
            end
            tspp_pkg::PH_ALGO: begin
                if (code_len == '0) begin
                    n_phase = tspp_pkg::PH_ERROR;
                    n_err   = tspp_pkg::ST_CORRUPT;
                end else begin
                    n_alg   = i_byte;
                    n_dlen  = code_len;
                    n_pos   = '0;
                    n_phase = tspp_pkg::PH_DIGEST;
                end
            end
            tspp_pkg::PH_DIGEST: begin
                emit_tok       = 1'b1;
                res.token_kind = tspp_pkg::TK_DIGEST;
                res.hash_code  = r_alg;
                res.data_byte  = i_byte;
                n_pos          = pos_inc;
                if (pos_inc >= r_dlen) begin
                    res.digest_end = 1'b1;
                    n_phase        = tspp_pkg::PH_TAIL;
                end
            end
            tspp_pkg::PH_TAIL: begin
            end
            default: begin
            end
        endcase

        if (i_last) begin
            res.done_res = 1'b1;
            unique case (n_phase) inside
                tspp_pkg::PH_MAGIC, tspp_pkg::PH_VERSION: res.status = tspp_pkg::ST_OVERFLOW;
                tspp_pkg::PH_ALGO, tspp_pkg::PH_DIGEST:   res.status = tspp_pkg::ST_CORRUPT;
                tspp_pkg::PH_TAIL:                        res.status = tspp_pkg::ST_OK;
                default:                                  res.status = n_err;
            endcase
            // End of file: rearm for the next one.
            n_phase    = tspp_pkg::PH_MAGIC;
            n_pos      = '0;
            n_dlen     = '0;
            n_alg      = '0;
            n_mismatch = 1'b0;
            n_err      = tspp_pkg::ST_OK;
        end
    end

    assign o_emit   = emit_tok | i_last;
    assign o_result = res;

endmodule

>>> hdl/timestamp_proof_header_parser.sv
// Top level of the proof-file header parser: stream ports, result register and skid stage.
// A result is registered in the output register, or in the skid slot while the sink stalls.
// Throughput: one byte per cycle while the skid slot is free; the parse state updates once per accepted byte.
// The skid stage lets a byte be accepted while the result register is held by the sink.
// Reset (synchronous, active low) returns the parser to the start of the magic header,
// empties both result slots and sets the expected version to one.
module timestamp_proof_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: expected version byte.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    // Byte stream in.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic        s_axis_tlast,   // last_byte
    // Result stream out.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] hash_code, [15:8] data_byte,
                                        // [16] digest_end, [19:17] status, [23:20] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] token_kind
    output logic        m_axis_tlast    // done_res
);

    logic              accept;
    logic              core_emit;
    tspp_pkg::t_result core_res;

    tspp_pkg::t_result r_out, n_out;
    logic              r_out_valid, n_out_valid;
    tspp_pkg::t_result r_skid, n_skid;
    logic              r_skid_valid, n_skid_valid;

    // The configuration register can always take a write.
    assign o_cfg_ready = 1'b1;

    // A byte is taken whenever the skid slot is free; the skid slot then
    // always has room for the result of that byte should the sink stall.
    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;

    tspp_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (accept),
        .i_byte     (s_axis_tdata),
        .i_last     (s_axis_tlast),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_emit     (core_emit),
        .o_result   (core_res)
    );

    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (!r_out_valid || m_axis_tready) begin
            // Output register is free or being emptied in this transfer.
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = core_res;
                n_out_valid = accept && core_emit;
            end
        end else if (accept && core_emit) begin
            // Sink is stalled: park the new result in the skid slot.
            n_skid       = core_res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.token_kind;
    assign m_axis_tlast  = r_out.done_res;
    assign m_axis_tdata  = {4'b0000, r_out.status, r_out.digest_end,
                            r_out.data_byte, r_out.hash_code};

endmodule
